[design/ppd_pkg.sv]
// ----------------------------------------------------------------------------
// ppd_pkg: shared types, constants and saturating helpers
// Holds the defaults of the projection block and the arithmetic helpers that
// its divider, multipliers and adder stages share.
// ----------------------------------------------------------------------------
package ppd_pkg;

   localparam int COORD_WIDTH_DEF    = 32;
   localparam int COEF_FRAC_BITS_DEF = 24;
   localparam int NORM_FRAC          = 32;
   localparam int NEAR_ZERO_LIMIT    = 3;

   localparam logic [63:0] MAX64 = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;

   // A 64 bit two's complement value with the flag of a clip.
   typedef struct packed {
      logic        sat;
      logic [63:0] val;
   } sat_val_type;

   // Applies a sign to a magnitude and saturates to the signed 64 bit range.
   function automatic sat_val_type from_mag(input logic neg, input logic [63:0] m);
      sat_val_type r;
      r.sat = 1'b0;
      r.val = m;
      if (!neg) begin
         if (m[63]) begin
            r.sat = 1'b1;
            r.val = MAX64;
         end
      end else begin
         if (m > MIN64) begin
            r.sat = 1'b1;
            r.val = MIN64;
         end else begin
            r.val = ~m + 64'd1;
         end
      end
      return r;
   endfunction

   // Saturating signed 64 bit sum.
   function automatic sat_val_type add_sat(input logic [63:0] a, input logic [63:0] b);
      sat_val_type r;
      logic [64:0] s;
      s     = {a[63], a} + {b[63], b};
      r.sat = 1'b0;
      r.val = s[63:0];
      if (s[64] != s[63]) begin
         r.sat = 1'b1;
         r.val = s[64] ? MIN64 : MAX64;
      end
      return r;
   endfunction

endpackage

[design/ppd_delay.sv]
// ----------------------------------------------------------------------------
// ppd_delay: enabled delay line
// Holds a word for a fixed number of pipeline steps so that it meets the
// values computed alongside it.
// ----------------------------------------------------------------------------
module ppd_delay #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] tap_ff [0:DEPTH-1];

   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign dout = tap_ff[DEPTH-1];

endmodule

[design/ppd_mul.sv]
// ----------------------------------------------------------------------------
// ppd_mul: pipelined fixed point multiplier
// Signed 64 by 64 bit product from four 32 bit partial products, shifted
// back by SH bits with rounding half away from zero, then saturated. The
// magnitudes, partial products, sum and result are registered in turn.
// ----------------------------------------------------------------------------
module ppd_mul #(
   parameter int SH = 32
) (
   input  logic                clock,
   input  logic                en,
   input  logic [63:0]         a,
   input  logic [63:0]         b,
   output ppd_pkg::sat_val_type res
);

   localparam logic [127:0] RND = 128'd1 << (SH - 1);

   logic [63:0]  am_ff, bm_ff;
   logic         neg1_ff, neg2_ff, neg3_ff;
   logic [63:0]  p00_ff, p01_ff, p10_ff, p11_ff;
   logic [127:0] full_ff;
   ppd_pkg::sat_val_type res_ff;
   logic         over;
   logic [63:0]  qm;

   always_comb begin
      over = (full_ff >> (64 + SH)) != 128'd0;
      qm   = 64'(full_ff >> SH);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         am_ff   <= a[63] ? (~a + 64'd1) : a;
         bm_ff   <= b[63] ? (~b + 64'd1) : b;
         neg1_ff <= a[63] ^ b[63];
         p00_ff  <= am_ff[31:0]  * bm_ff[31:0];
         p01_ff  <= am_ff[31:0]  * bm_ff[63:32];
         p10_ff  <= am_ff[63:32] * bm_ff[31:0];
         p11_ff  <= am_ff[63:32] * bm_ff[63:32];
         neg2_ff <= neg1_ff;
         full_ff <= {64'd0, p00_ff} + {32'd0, p01_ff, 32'd0} + {32'd0, p10_ff, 32'd0}
                  + {p11_ff, 64'd0} + RND;
         neg3_ff <= neg2_ff;
         res_ff  <= ppd_pkg::from_mag(neg3_ff, over ? '1 : qm);
      end
   end

   assign res = res_ff;

endmodule

[design/ppd_div.sv]
// ----------------------------------------------------------------------------
// ppd_div: pipelined normalising divider
// Divides x and y by z with 32 extra fraction bits, one quotient bit per
// stage, rounds half away from zero and saturates. A depth close to zero
// bypasses the quotient and passes x and y through, widened by 16 bits.
// ----------------------------------------------------------------------------
module ppd_div #(
   parameter int W = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic         in_valid,
   input  logic [W-1:0] x,
   input  logic [W-1:0] y,
   input  logic [W-1:0] z,
   output logic         out_valid,
   output logic [63:0]  xp,
   output logic [63:0]  yp,
   output logic         nearz,
   output logic         sat
);

   localparam int NB = W + ppd_pkg::NORM_FRAC;

   logic [W-1:0]  rx_ff [0:NB];
   logic [W-1:0]  ry_ff [0:NB];
   logic [NB-1:0] nx_ff [0:NB];
   logic [NB-1:0] ny_ff [0:NB];
   logic [NB-1:0] qx_ff [0:NB];
   logic [NB-1:0] qy_ff [0:NB];
   logic [W-1:0]  d_ff  [0:NB];
   logic [W-1:0]  xs_ff [0:NB];
   logic [W-1:0]  ys_ff [0:NB];
   logic [NB:0]   sx_ff, sy_ff, nz_ff, v_ff;

   logic [W-1:0]  mx, my, mz;

   always_comb begin
      mx = x[W-1] ? (~x + W'(1)) : x;
      my = y[W-1] ? (~y + W'(1)) : y;
      mz = z[W-1] ? (~z + W'(1)) : z;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rx_ff[0] <= '0;
         ry_ff[0] <= '0;
         qx_ff[0] <= '0;
         qy_ff[0] <= '0;
         nx_ff[0] <= {mx, {ppd_pkg::NORM_FRAC{1'b0}}};
         ny_ff[0] <= {my, {ppd_pkg::NORM_FRAC{1'b0}}};
         d_ff[0]  <= mz;
         xs_ff[0] <= x;
         ys_ff[0] <= y;
         sx_ff[0] <= x[W-1] ^ z[W-1];
         sy_ff[0] <= y[W-1] ^ z[W-1];
         nz_ff[0] <= mz <= W'(ppd_pkg::NEAR_ZERO_LIMIT);
      end
   end

   for (genvar i = 1; i <= NB; i++) begin : g_step
      logic [W:0] remx2, remy2;
      logic       gex, gey;

      always_comb begin
         remx2 = {rx_ff[i-1], nx_ff[i-1][NB-1]};
         remy2 = {ry_ff[i-1], ny_ff[i-1][NB-1]};
         gex   = remx2 >= {1'b0, d_ff[i-1]};
         gey   = remy2 >= {1'b0, d_ff[i-1]};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rx_ff[i] <= gex ? W'(remx2 - {1'b0, d_ff[i-1]}) : remx2[W-1:0];
            ry_ff[i] <= gey ? W'(remy2 - {1'b0, d_ff[i-1]}) : remy2[W-1:0];
            qx_ff[i] <= {qx_ff[i-1][NB-2:0], gex};
            qy_ff[i] <= {qy_ff[i-1][NB-2:0], gey};
            nx_ff[i] <= nx_ff[i-1] << 1;
            ny_ff[i] <= ny_ff[i-1] << 1;
            d_ff[i]  <= d_ff[i-1];
            xs_ff[i] <= xs_ff[i-1];
            ys_ff[i] <= ys_ff[i-1];
            sx_ff[i] <= sx_ff[i-1];
            sy_ff[i] <= sy_ff[i-1];
            nz_ff[i] <= nz_ff[i-1];
         end
      end
   end

   // Rounding and sign stages.
   logic [NB:0]   qrx_ff, qry_ff;
   logic          rsx_ff, rsy_ff, rnz_ff, rv_ff, ov_ff;
   logic [W-1:0]  rxs_ff, rys_ff;
   logic [63:0]   xp_ff, yp_ff;
   logic          nz_out_ff, sat_ff;
   ppd_pkg::sat_val_type fx, fy;
   logic          ovx, ovy;

   always_comb begin
      ovx = (qrx_ff >> 64) != '0;
      ovy = (qry_ff >> 64) != '0;
      fx  = ppd_pkg::from_mag(rsx_ff, ovx ? '1 : 64'(qrx_ff));
      fy  = ppd_pkg::from_mag(rsy_ff, ovy ? '1 : 64'(qry_ff));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         qrx_ff    <= {1'b0, qx_ff[NB]}
                    + (NB+1)'(rx_ff[NB] >= d_ff[NB] - rx_ff[NB]);
         qry_ff    <= {1'b0, qy_ff[NB]}
                    + (NB+1)'(ry_ff[NB] >= d_ff[NB] - ry_ff[NB]);
         rsx_ff    <= sx_ff[NB];
         rsy_ff    <= sy_ff[NB];
         rnz_ff    <= nz_ff[NB];
         rxs_ff    <= xs_ff[NB];
         rys_ff    <= ys_ff[NB];
         nz_out_ff <= rnz_ff;
         if (rnz_ff) begin
            xp_ff  <= 64'($signed(rxs_ff)) << 16;
            yp_ff  <= 64'($signed(rys_ff)) << 16;
            sat_ff <= 1'b0;
         end else begin
            xp_ff  <= fx.val;
            yp_ff  <= fy.val;
            sat_ff <= fx.sat | fy.sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff  <= '0;
         rv_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else if (en) begin
         v_ff  <= {v_ff[NB-1:0], in_valid};
         rv_ff <= v_ff[NB];
         ov_ff <= rv_ff;
      end
   end

   assign out_valid = ov_ff;
   assign xp        = xp_ff;
   assign yp        = yp_ff;
   assign nearz     = nz_out_ff;
   assign sat       = sat_ff;

endmodule

[design/pinhole_projection_with_distortion.sv]
// ----------------------------------------------------------------------------
// pinhole_projection_with_distortion: pinhole projection with lens distortion
// Projects a camera frame point to a pixel position, applying radial and
// tangential distortion, with saturation of every intermediate value.
// ----------------------------------------------------------------------------
//
//  Channel   Direction   Handshake                 Word
//  req_      in          req_valid / req_stall     point_x, point_y, point_z
//  rsp_      out         rsp_valid / rsp_stall     pixel_x, pixel_y, flags
//  APB       in/out      psel, penable, pready     one register a 64 bit write
//
// A word is accepted in every clock cycle in which the output is not stalled.
// Its result passes first through the bit-per-stage divider and then through
// the chain of multipliers and adders behind it.
// Reset is synchronous and clears the valid bits and the configuration registers only.
// A stalled result holds the whole pipeline; no word is lost or repeated.
//
module pinhole_projection_with_distortion #(
   parameter int COORD_WIDTH    = ppd_pkg::COORD_WIDTH_DEF,
   parameter int COEF_FRAC_BITS = ppd_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [COORD_WIDTH-1:0] req_point_x,
   input  logic [COORD_WIDTH-1:0] req_point_y,
   input  logic [COORD_WIDTH-1:0] req_point_z,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [COORD_WIDTH-1:0] rsp_pixel_x,
   output logic [COORD_WIDTH-1:0] rsp_pixel_y,
   output logic                   rsp_depth_near_zero,
   output logic                   rsp_saturated,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [5:0]             paddr,
   input  logic [63:0]            pwdata,
   output logic [63:0]            prdata,
   output logic                   pready
);

   localparam int LAST = 30;
   localparam int NF   = ppd_pkg::NORM_FRAC;
   localparam logic [63:0] LIM = 64'((64'd1 << (COORD_WIDTH - 1)) - 64'd1);

   typedef enum logic [2:0] {
      REG_FOCAL_X, REG_FOCAL_Y, REG_CENTER, REG_K1,
      REG_K2, REG_K3, REG_P1, REG_P2
   } csr_index_type;

   // ---------------------------------------------------------------------
   // Configuration registers. Registers sit 8 bytes apart.
   // ---------------------------------------------------------------------
   logic [31:0] focal_x_ff, focal_y_ff;
   logic [63:0] center_ff;
   logic [31:0] k1_ff, k2_ff, k3_ff, p1_ff, p2_ff;
   csr_index_type csr_index;

   assign csr_index = csr_index_type'(paddr[5:3]);
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_x_ff <= '0;
         focal_y_ff <= '0;
         center_ff  <= '0;
         k1_ff      <= '0;
         k2_ff      <= '0;
         k3_ff      <= '0;
         p1_ff      <= '0;
         p2_ff      <= '0;
      end else if (psel && penable && pwrite) begin
         unique case (csr_index)
            REG_FOCAL_X: focal_x_ff <= pwdata[31:0];
            REG_FOCAL_Y: focal_y_ff <= pwdata[31:0];
            REG_CENTER:  center_ff  <= pwdata;
            REG_K1:      k1_ff      <= pwdata[31:0];
            REG_K2:      k2_ff      <= pwdata[31:0];
            REG_K3:      k3_ff      <= pwdata[31:0];
            REG_P1:      p1_ff      <= pwdata[31:0];
            REG_P2:      p2_ff      <= pwdata[31:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_FOCAL_X: prdata = {32'd0, focal_x_ff};
         REG_FOCAL_Y: prdata = {32'd0, focal_y_ff};
         REG_CENTER:  prdata = center_ff;
         REG_K1:      prdata = {32'd0, k1_ff};
         REG_K2:      prdata = {32'd0, k2_ff};
         REG_K3:      prdata = {32'd0, k3_ff};
         REG_P1:      prdata = {32'd0, p1_ff};
         REG_P2:      prdata = {32'd0, p2_ff};
      endcase
   end

   // The coefficients are signed, the focal lengths and the centre are not.
   logic [63:0] k1, k2, k3, p1, p2, fx, fy, cx, cy;
   assign k1 = {{32{k1_ff[31]}}, k1_ff};
   assign k2 = {{32{k2_ff[31]}}, k2_ff};
   assign k3 = {{32{k3_ff[31]}}, k3_ff};
   assign p1 = {{32{p1_ff[31]}}, p1_ff};
   assign p2 = {{32{p2_ff[31]}}, p2_ff};
   assign fx = {32'd0, focal_x_ff};
   assign fy = {32'd0, focal_y_ff};
   assign cx = {32'd0, center_ff[31:0]};
   assign cy = {32'd0, center_ff[63:32]};

   // ---------------------------------------------------------------------
   // Flow control. The pipeline moves as one; it halts only while the
   // output register holds a word that the receiver does not take.
   // ---------------------------------------------------------------------
   logic en;
   logic rsp_valid_ff;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   // ---------------------------------------------------------------------
   // Normalisation: x/z and y/z. Its output is step 0 of the chain below;
   // the suffix of each name gives the step at which the value is held.
   // ---------------------------------------------------------------------
   logic        div_valid, div_nz, div_sat;
   logic [63:0] xp0, yp0;

   ppd_div #(.W(COORD_WIDTH)) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .x         (req_point_x),
      .y         (req_point_y),
      .z         (req_point_z),
      .out_valid (div_valid),
      .xp        (xp0),
      .yp        (yp0),
      .nearz     (div_nz),
      .sat       (div_sat)
   );

   // Copies of the normalised point for the later multiplications.
   logic [63:0] xp4, yp4, xp9, yp9, xp13, yp13, xp17, yp17;

   ppd_delay #(.WIDTH(128), .DEPTH(4)) u_dly_p4 (
      .clock(clock), .en(en), .din({xp0, yp0}), .dout({xp4, yp4}));
   ppd_delay #(.WIDTH(128), .DEPTH(5)) u_dly_p9 (
      .clock(clock), .en(en), .din({xp4, yp4}), .dout({xp9, yp9}));
   ppd_delay #(.WIDTH(128), .DEPTH(4)) u_dly_p13 (
      .clock(clock), .en(en), .din({xp9, yp9}), .dout({xp13, yp13}));
   ppd_delay #(.WIDTH(128), .DEPTH(4)) u_dly_p17 (
      .clock(clock), .en(en), .din({xp13, yp13}), .dout({xp17, yp17}));

   // Squares and the first half of the tangential cross term.
   ppd_pkg::sat_val_type xp2_4, yp2_4, qx_4, qy_4;

   ppd_mul #(.SH(NF)) u_xp2 (.clock(clock), .en(en), .a(xp0), .b(xp0), .res(xp2_4));
   ppd_mul #(.SH(NF)) u_yp2 (.clock(clock), .en(en), .a(yp0), .b(yp0), .res(yp2_4));
   ppd_mul #(.SH(COEF_FRAC_BITS)) u_qx (.clock(clock), .en(en), .a(p1), .b(xp0), .res(qx_4));
   ppd_mul #(.SH(COEF_FRAC_BITS)) u_qy (.clock(clock), .en(en), .a(p2), .b(yp0), .res(qy_4));

   // r^2 and twice the squares.
   ppd_pkg::sat_val_type r2_5_ff, dx_5_ff, dy_5_ff, tx_6_ff, ty_6_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         r2_5_ff <= ppd_pkg::add_sat(xp2_4.val, yp2_4.val);
         dx_5_ff <= ppd_pkg::add_sat(xp2_4.val, xp2_4.val);
         dy_5_ff <= ppd_pkg::add_sat(yp2_4.val, yp2_4.val);
         tx_6_ff <= ppd_pkg::add_sat(r2_5_ff.val, dx_5_ff.val);
         ty_6_ff <= ppd_pkg::add_sat(r2_5_ff.val, dy_5_ff.val);
      end
   end

   ppd_pkg::sat_val_type ux_8, uy_8, r4_9, e1_9, vx_10, vy_10;
   logic [63:0] r2_9;

   ppd_mul #(.SH(NF)) u_ux (.clock(clock), .en(en), .a(qx_4.val), .b(yp4), .res(ux_8));
   ppd_mul #(.SH(NF)) u_uy (.clock(clock), .en(en), .a(qy_4.val), .b(xp4), .res(uy_8));
   ppd_mul #(.SH(NF)) u_r4 (.clock(clock), .en(en), .a(r2_5_ff.val), .b(r2_5_ff.val),
                            .res(r4_9));
   ppd_mul #(.SH(COEF_FRAC_BITS)) u_e1 (.clock(clock), .en(en), .a(k1), .b(r2_5_ff.val),
                                        .res(e1_9));
   ppd_mul #(.SH(COEF_FRAC_BITS)) u_vx (.clock(clock), .en(en), .a(p2), .b(tx_6_ff.val),
                                        .res(vx_10));
   ppd_mul #(.SH(COEF_FRAC_BITS)) u_vy (.clock(clock), .en(en), .a(p1), .b(ty_6_ff.val),
                                        .res(vy_10));
   ppd_delay #(.WIDTH(64), .DEPTH(4)) u_dly_r2 (
      .clock(clock), .en(en), .din(r2_5_ff.val), .dout(r2_9));

   // Doubled cross term.
   ppd_pkg::sat_val_type wx_9_ff, wy_9_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         wx_9_ff <= ppd_pkg::add_sat(ux_8.val, ux_8.val);
         wy_9_ff <= ppd_pkg::add_sat(uy_8.val, uy_8.val);
      end
   end

   // Radial terms, one power of r^2 after the other.
   ppd_pkg::sat_val_type r6_13, e2_13, c1x_13, c1y_13;
   ppd_pkg::sat_val_type e3_17, c2x_17, c2y_17, c3x_21, c3y_21;

   ppd_mul #(.SH(NF)) u_r6 (.clock(clock), .en(en), .a(r2_9), .b(r4_9.val), .res(r6_13));
   ppd_mul #(.SH(COEF_FRAC_BITS)) u_e2 (.clock(clock), .en(en), .a(k2), .b(r4_9.val),
                                        .res(e2_13));
   ppd_mul #(.SH(NF)) u_c1x (.clock(clock), .en(en), .a(e1_9.val), .b(xp9), .res(c1x_13));
   ppd_mul #(.SH(NF)) u_c1y (.clock(clock), .en(en), .a(e1_9.val), .b(yp9), .res(c1y_13));
   ppd_mul #(.SH(COEF_FRAC_BITS)) u_e3 (.clock(clock), .en(en), .a(k3), .b(r6_13.val),
                                        .res(e3_17));
   ppd_mul #(.SH(NF)) u_c2x (.clock(clock), .en(en), .a(e2_13.val), .b(xp13), .res(c2x_17));
   ppd_mul #(.SH(NF)) u_c2y (.clock(clock), .en(en), .a(e2_13.val), .b(yp13), .res(c2y_17));
   ppd_mul #(.SH(NF)) u_c3x (.clock(clock), .en(en), .a(e3_17.val), .b(xp17), .res(c3x_21));
   ppd_mul #(.SH(NF)) u_c3y (.clock(clock), .en(en), .a(e3_17.val), .b(yp17), .res(c3y_21));

   // The sums saturate one term at a time, so their order is kept.
   ppd_pkg::sat_val_type s1x_14_ff, s1y_14_ff, s2x_18_ff, s2y_18_ff;
   ppd_pkg::sat_val_type s3x_22_ff, s3y_22_ff, s4x_23_ff, s4y_23_ff;
   ppd_pkg::sat_val_type s5x_24_ff, s5y_24_ff;
   logic [63:0] s1x_17, s1y_17, s2x_21, s2y_21, vx_22, vy_22, wx_23, wy_23;

   ppd_delay #(.WIDTH(128), .DEPTH(3)) u_dly_s1 (
      .clock(clock), .en(en), .din({s1x_14_ff.val, s1y_14_ff.val}), .dout({s1x_17, s1y_17}));
   ppd_delay #(.WIDTH(128), .DEPTH(3)) u_dly_s2 (
      .clock(clock), .en(en), .din({s2x_18_ff.val, s2y_18_ff.val}), .dout({s2x_21, s2y_21}));
   ppd_delay #(.WIDTH(128), .DEPTH(12)) u_dly_v (
      .clock(clock), .en(en), .din({vx_10.val, vy_10.val}), .dout({vx_22, vy_22}));
   ppd_delay #(.WIDTH(128), .DEPTH(14)) u_dly_w (
      .clock(clock), .en(en), .din({wx_9_ff.val, wy_9_ff.val}), .dout({wx_23, wy_23}));

   always_ff @(posedge clock) begin
      if (en) begin
         s1x_14_ff <= ppd_pkg::add_sat(xp13, c1x_13.val);
         s1y_14_ff <= ppd_pkg::add_sat(yp13, c1y_13.val);
         s2x_18_ff <= ppd_pkg::add_sat(s1x_17, c2x_17.val);
         s2y_18_ff <= ppd_pkg::add_sat(s1y_17, c2y_17.val);
         s3x_22_ff <= ppd_pkg::add_sat(s2x_21, c3x_21.val);
         s3y_22_ff <= ppd_pkg::add_sat(s2y_21, c3y_21.val);
         s4x_23_ff <= ppd_pkg::add_sat(s3x_22_ff.val, vx_22);
         s4y_23_ff <= ppd_pkg::add_sat(s3y_22_ff.val, vy_22);
         s5x_24_ff <= ppd_pkg::add_sat(s4x_23_ff.val, wx_23);
         s5y_24_ff <= ppd_pkg::add_sat(s4y_23_ff.val, wy_23);
      end
   end

   // Focal scaling and the principal point.
   ppd_pkg::sat_val_type px_28, py_28, ox_29_ff, oy_29_ff;

   ppd_mul #(.SH(NF)) u_px (.clock(clock), .en(en), .a(fx), .b(s5x_24_ff.val), .res(px_28));
   ppd_mul #(.SH(NF)) u_py (.clock(clock), .en(en), .a(fy), .b(s5y_24_ff.val), .res(py_28));

   always_ff @(posedge clock) begin
      if (en) begin
         ox_29_ff <= ppd_pkg::add_sat(px_28.val, cx);
         oy_29_ff <= ppd_pkg::add_sat(py_28.val, cy);
      end
   end

   // Final clamp to the pixel word width.
   logic [COORD_WIDTH-1:0] pix_x, pix_y;
   logic                   clip_x, clip_y;

   always_comb begin
      clip_x = 1'b0;
      clip_y = 1'b0;
      pix_x  = ox_29_ff.val[COORD_WIDTH-1:0];
      pix_y  = oy_29_ff.val[COORD_WIDTH-1:0];
      if ($signed(ox_29_ff.val) > $signed(LIM)) begin
         clip_x = 1'b1;
         pix_x  = LIM[COORD_WIDTH-1:0];
      end else if ($signed(ox_29_ff.val) < $signed(~LIM)) begin
         clip_x = 1'b1;
         pix_x  = ~LIM[COORD_WIDTH-1:0];
      end
      if ($signed(oy_29_ff.val) > $signed(LIM)) begin
         clip_y = 1'b1;
         pix_y  = LIM[COORD_WIDTH-1:0];
      end else if ($signed(oy_29_ff.val) < $signed(~LIM)) begin
         clip_y = 1'b1;
         pix_y  = ~LIM[COORD_WIDTH-1:0];
      end
   end

   // ---------------------------------------------------------------------
   // Valid, near-depth and clip bits travel with the word. Each unit's
   // clip flag joins the word's flag at the step where the unit's result
   // is held.
   // ---------------------------------------------------------------------
   logic [LAST-1:0] tap;
   logic [LAST-1:1] vld_ff, nz_ff, sat_ff;
   logic [COORD_WIDTH-1:0] rsp_pixel_x_ff, rsp_pixel_y_ff;
   logic rsp_nz_ff, rsp_sat_ff;

   always_comb begin
      tap     = '0;
      tap[4]  = xp2_4.sat | yp2_4.sat | qx_4.sat | qy_4.sat;
      tap[5]  = r2_5_ff.sat | dx_5_ff.sat | dy_5_ff.sat;
      tap[6]  = tx_6_ff.sat | ty_6_ff.sat;
      tap[8]  = ux_8.sat | uy_8.sat;
      tap[9]  = r4_9.sat | e1_9.sat | wx_9_ff.sat | wy_9_ff.sat;
      tap[10] = vx_10.sat | vy_10.sat;
      tap[13] = r6_13.sat | e2_13.sat | c1x_13.sat | c1y_13.sat;
      tap[14] = s1x_14_ff.sat | s1y_14_ff.sat;
      tap[17] = e3_17.sat | c2x_17.sat | c2y_17.sat;
      tap[18] = s2x_18_ff.sat | s2y_18_ff.sat;
      tap[21] = c3x_21.sat | c3y_21.sat;
      tap[22] = s3x_22_ff.sat | s3y_22_ff.sat;
      tap[23] = s4x_23_ff.sat | s4y_23_ff.sat;
      tap[24] = s5x_24_ff.sat | s5y_24_ff.sat;
      tap[28] = px_28.sat | py_28.sat;
      tap[29] = ox_29_ff.sat | oy_29_ff.sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= {vld_ff[LAST-2:1], div_valid};
         rsp_valid_ff <= vld_ff[LAST-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nz_ff          <= {nz_ff[LAST-2:1], div_nz};
         sat_ff         <= {sat_ff[LAST-2:1] | tap[LAST-2:1], div_sat | tap[0]};
         rsp_nz_ff      <= nz_ff[LAST-1];
         rsp_sat_ff     <= sat_ff[LAST-1] | tap[LAST-1] | clip_x | clip_y;
         rsp_pixel_x_ff <= pix_x;
         rsp_pixel_y_ff <= pix_y;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_pixel_x         = rsp_pixel_x_ff;
   assign rsp_pixel_y         = rsp_pixel_y_ff;
   assign rsp_depth_near_zero = rsp_nz_ff;
   assign rsp_saturated       = rsp_sat_ff;

endmodule

[design/ppd_checker.sv]
// ----------------------------------------------------------------------------
// ppd_checker: port level checks of the projection block
// Watches the ports of the top level for flow control slips.
// ----------------------------------------------------------------------------
module ppd_checker #(
   parameter int COORD_WIDTH = ppd_pkg::COORD_WIDTH_DEF
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [COORD_WIDTH-1:0] rsp_pixel_x,
   input logic [COORD_WIDTH-1:0] rsp_pixel_y,
   input logic                   rsp_depth_near_zero,
   input logic                   rsp_saturated
);

   // No result is offered in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered straight after reset");

   // The input is held back exactly when a waiting result is refused.
   a_stall_link: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall does not follow the output stall");

   // A refused result stays offered and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_x) &&
      $stable(rsp_pixel_y) && $stable(rsp_saturated) && $stable(rsp_depth_near_zero))
      else $error("refused result changed");

endmodule

bind pinhole_projection_with_distortion ppd_checker #(.COORD_WIDTH(COORD_WIDTH)) u_ppd_checker (.*);

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the distorting pinhole projection
// Points are fed through the request channel in several phases, each with its
// own lens setting and a set pattern of sender gaps and receiver stalls.
// Every accepted point is projected by a predictor in this file and the
// expected pixel word is queued; the response monitor compares each returned
// word, field by field, with the oldest expectation.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int HOLD_CYCLES = 400;   // long receiver hold-off in the pressure phase
   localparam int DRAIN_WAIT  = 130;   // above the block's latency at the default width

   // Register map: eight registers at 8 byte steps, as one is 64 bits wide.
   typedef enum int {
      REG_FOCAL_X, REG_FOCAL_Y, REG_OPTICAL_CENTER, REG_RADIAL_K1,
      REG_RADIAL_K2, REG_RADIAL_K3, REG_TANGENTIAL_P1, REG_TANGENTIAL_P2
   } lens_reg_type;

   typedef struct {
      logic [31:0] x, y, z;
   } point_word_type;

   typedef struct {
      logic [31:0] px, py;
      logic        near_zero, clipped;
   } pixel_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_point_x = '0, req_point_y = '0, req_point_z = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_pixel_x, rsp_pixel_y;
   logic        rsp_depth_near_zero, rsp_saturated;
   logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [5:0]  paddr = '0;
   logic [63:0] pwdata = '0;
   logic [63:0] prdata;
   logic        pready;

   // Lens setting as the block holds it, indexed by lens_reg_type.
   logic [63:0] lens_cfg [8];
   logic        clip_flag;

   point_word_type point_q [$];
   pixel_word_type pixel_q [$];

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   bit pressure_phase = 1'b0;
   bit hold_done = 1'b0;
   int hold_left = 0;
   int mismatches = 0;

   pinhole_projection_with_distortion u_dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Predictor. All intermediates are signed 64 bit values with 32
   // fraction bits; any clip raises clip_flag.
   // ---------------------------------------------------------------------
   function automatic logic [63:0] magnitude(input logic [63:0] a);
      return a[63] ? (~a + 64'd1) : a;
   endfunction

   function automatic logic [63:0] signed_clip(input logic neg, input logic [63:0] m);
      if (!neg) begin
         if (m[63]) begin
            clip_flag = 1'b1;
            return ppd_pkg::MAX64;
         end
         return m;
      end
      if (m > ppd_pkg::MIN64) begin
         clip_flag = 1'b1;
         return ppd_pkg::MIN64;
      end
      return ~m + 64'd1;
   endfunction

   // Exact product, shifted right by sh with rounding half away from zero.
   function automatic logic [63:0] mul_round(input logic [63:0] a, input logic [63:0] b,
                                             input int sh);
      logic [127:0] p;
      p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
      p = (p + (128'd1 << (sh - 1))) >> sh;
      return signed_clip(a[63] ^ b[63], (p[127:64] != 0) ? '1 : p[63:0]);
   endfunction

   function automatic logic [63:0] sum_sat(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
         clip_flag = 1'b1;
         return s[64] ? ppd_pkg::MIN64 : ppd_pkg::MAX64;
      end
      return s[63:0];
   endfunction

   // (x << 32) / z, rounded half away from zero.
   function automatic logic [63:0] div_round(input logic [63:0] x, input logic [63:0] z);
      logic [127:0] n, d, q, r;
      n = {64'd0, magnitude(x)} << 32;
      d = {64'd0, magnitude(z)};
      q = n / d;
      r = n % d;
      if (r >= d - r)
         q = q + 128'd1;
      return signed_clip(x[63] ^ z[63], (q[127:64] != 0) ? '1 : q[63:0]);
   endfunction

   function automatic logic [63:0] coef(input lens_reg_type idx);
      return {{32{lens_cfg[idx][31]}}, lens_cfg[idx][31:0]};
   endfunction

   function automatic logic [63:0] apply_distortion(
         input logic [63:0] a, input logic [63:0] b, input logic [63:0] r2,
         input logic [63:0] r4, input logic [63:0] r6, input logic [63:0] a2,
         input logic [63:0] pa, input logic [63:0] pb);
      logic [63:0] s, t;
      s = sum_sat(a, mul_round(mul_round(coef(REG_RADIAL_K1), r2, 24), a, 32));
      s = sum_sat(s, mul_round(mul_round(coef(REG_RADIAL_K2), r4, 24), a, 32));
      s = sum_sat(s, mul_round(mul_round(coef(REG_RADIAL_K3), r6, 24), a, 32));
      t = sum_sat(r2, sum_sat(a2, a2));
      s = sum_sat(s, mul_round(pa, t, 24));
      t = mul_round(mul_round(pb, a, 24), b, 32);
      return sum_sat(s, sum_sat(t, t));
   endfunction

   function automatic logic [31:0] to_pixel(input logic [63:0] focal, input logic [63:0] centre,
                                            input logic [63:0] v);
      logic [63:0] p;
      p = sum_sat(mul_round(focal, v, 32), centre);
      if ($signed(p) > 64'sh7FFF_FFFF) begin
         clip_flag = 1'b1;
         return 32'h7FFF_FFFF;
      end
      if ($signed(p) < -64'sh8000_0000) begin
         clip_flag = 1'b1;
         return 32'h8000_0000;
      end
      return p[31:0];
   endfunction

   function automatic pixel_word_type project_point(input point_word_type w);
      pixel_word_type o;
      logic [63:0]    x, y, z, xn, yn, xn2, yn2, r2, r4, r6, xd, yd;
      x = {{32{w.x[31]}}, w.x};
      y = {{32{w.y[31]}}, w.y};
      z = {{32{w.z[31]}}, w.z};
      clip_flag = 1'b0;
      o.near_zero = (magnitude(z) <= ppd_pkg::NEAR_ZERO_LIMIT);
      if (o.near_zero) begin
         // The divide is skipped: Q16.16 is widened to 32 fraction bits.
         xn = x << 16;
         yn = y << 16;
      end else begin
         xn = div_round(x, z);
         yn = div_round(y, z);
      end
      xn2 = mul_round(xn, xn, 32);
      yn2 = mul_round(yn, yn, 32);
      r2  = sum_sat(xn2, yn2);
      r4  = mul_round(r2, r2, 32);
      r6  = mul_round(r2, r4, 32);
      xd = apply_distortion(xn, yn, r2, r4, r6, xn2,
                            coef(REG_TANGENTIAL_P2), coef(REG_TANGENTIAL_P1));
      yd = apply_distortion(yn, xn, r2, r4, r6, yn2,
                            coef(REG_TANGENTIAL_P1), coef(REG_TANGENTIAL_P2));
      o.px = to_pixel({32'd0, lens_cfg[REG_FOCAL_X][31:0]},
                      {32'd0, lens_cfg[REG_OPTICAL_CENTER][31:0]}, xd);
      o.py = to_pixel({32'd0, lens_cfg[REG_FOCAL_Y][31:0]},
                      {32'd0, lens_cfg[REG_OPTICAL_CENTER][63:32]}, yd);
      o.clipped = clip_flag;
      return o;
   endfunction

   // ---------------------------------------------------------------------
   // Request driver. A new word is only offered once the previous one has
   // been taken, and a stalled word is held unchanged. The expectation is
   // queued at the edge at which the block accepts the word.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : drive_points
      point_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            w.x = req_point_x;
            w.y = req_point_y;
            w.z = req_point_z;
            pixel_q = {pixel_q, project_point(w)};
         end
         if (point_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            w = point_q.pop_front();
            req_valid   <= 1'b1;
            req_point_x <= w.x;
            req_point_y <= w.y;
            req_point_z <= w.z;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response monitor. It also drives the stall, including the one long
   // hold-off of the pressure phase, which fills the pipeline and makes the
   // block stall its own input.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : check_pixels
      pixel_word_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pixel_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected pixel word x=%h y=%h", $realtime,
                        rsp_pixel_x, rsp_pixel_y);
         end else begin
            e = pixel_q.pop_front();
            if (rsp_pixel_x !== e.px || rsp_pixel_y !== e.py ||
                rsp_depth_near_zero !== e.near_zero || rsp_saturated !== e.clipped) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: pixel word mismatch: expected x=%h y=%h nz=%b sat=%b,",
                           $realtime, e.px, e.py, e.near_zero, e.clipped,
                           " got x=%h y=%h nz=%b sat=%b",
                           rsp_pixel_x, rsp_pixel_y, rsp_depth_near_zero, rsp_saturated);
            end
         end
      end
      if (pressure_phase && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   task automatic write_reg(input lens_reg_type idx, input logic [63:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= 6'(idx * 8);
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      lens_cfg[idx] = (idx == REG_OPTICAL_CENTER) ? value : {32'd0, value[31:0]};
   endtask

   task automatic write_lens(input logic [63:0] fx, input logic [63:0] fy,
                             input logic [63:0] centre, input logic [31:0] k1,
                             input logic [31:0] k2, input logic [31:0] k3,
                             input logic [31:0] p1, input logic [31:0] p2);
      write_reg(REG_FOCAL_X, fx);
      write_reg(REG_FOCAL_Y, fy);
      write_reg(REG_OPTICAL_CENTER, centre);
      write_reg(REG_RADIAL_K1, {32'd0, k1});
      write_reg(REG_RADIAL_K2, {32'd0, k2});
      write_reg(REG_RADIAL_K3, {32'd0, k3});
      write_reg(REG_TANGENTIAL_P1, {32'd0, p1});
      write_reg(REG_TANGENTIAL_P2, {32'd0, p2});
   endtask

   // A plausible lens: coefficients of up to about one half in Q8.24.
   task automatic write_random_lens();
      write_lens($urandom_range(2000) << 16 | $urandom_range(16'hFFFF),
                 $urandom_range(2000) << 16 | $urandom_range(16'hFFFF),
                 {32'($urandom_range(1000) << 16), 32'($urandom_range(1000) << 16)},
                 $urandom_range(32'h0100_0000) - 32'h0080_0000,
                 $urandom_range(32'h0040_0000) - 32'h0020_0000,
                 $urandom_range(32'h0010_0000) - 32'h0008_0000,
                 $urandom_range(32'h0008_0000) - 32'h0004_0000,
                 $urandom_range(32'h0008_0000) - 32'h0004_0000);
   endtask

   task automatic add_point(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
      point_word_type w;
      w.x = x;
      w.y = y;
      w.z = z;
      point_q = {point_q, w};
   endtask

   // Mostly points in front of or behind the camera that land near the
   // image, with some near-zero depths and some words of raw noise.
   task automatic add_random_points(input int count);
      int          kind;
      logic [31:0] z, span;
      repeat (count) begin
         kind = $urandom_range(99);
         if (kind < 60) begin
            z    = $urandom_range(32'h0080_0000, 32'h0001_0000);
            span = z << 1;
            if ($urandom_range(1))
               z = -z;
            add_point($urandom_range(span) - (span >> 1), $urandom_range(span) - (span >> 1), z);
         end else if (kind < 75) begin
            add_point($urandom_range(32'h0004_0000) - 32'h0002_0000,
                      $urandom_range(32'h0004_0000) - 32'h0002_0000,
                      $urandom_range(10) - 5);
         end else begin
            add_point($urandom, $urandom, $urandom);
         end
      end
   endtask

   task automatic run_until_quiet();
      while (point_q.size() != 0 || req_valid || pixel_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < 8; i++)
         lens_cfg[i] = '0;

      // Directed words against a typical lens, with no idling.
      write_lens(64'd500 << 16, 64'd480 << 16, {32'd240 << 16, 32'd320 << 16},
                 32'hFFCC_CCCD, 32'h000C_CCCD, 32'h0000_4189, 32'h0000_4189,
                 32'hFFFF_7CEE);
      add_point(32'h0, 32'h0, 32'h0001_0000);
      add_point(32'h0001_0000, 32'h0001_0000, 32'h0002_0000);
      add_point(32'hFFFF_0000, 32'h0000_8000, 32'hFFFD_0000);
      add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      add_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      add_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
      // Depth at and just past the near-zero limit, both signs.
      add_point(32'h0000_1000, 32'hFFFF_F000, 32'h0);
      add_point(32'h0000_1000, 32'h0000_2000, 32'h3);
      add_point(32'h0000_1000, 32'h0000_2000, 32'hFFFF_FFFD);
      add_point(32'h0000_1000, 32'h0000_2000, 32'h4);
      add_point(32'h0000_1000, 32'h0000_2000, 32'hFFFF_FFFC);
      add_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
      // Large and small quotients, with depths of both signs.
      add_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFB);
      add_point(32'h7FFF_FFFF, 32'h0000_0001, 32'h0000_0005);
      add_point(32'h0000_0001, 32'h0000_0003, 32'h0000_0006);
      add_point(32'h0000_8000, 32'hFFFF_8000, 32'h0001_0000);
      add_point(32'h0, 32'h7FFF_FFFF, 32'h8000_0000);
      run_until_quiet();

      // Plausible lens, no idling.
      write_random_lens();
      add_random_points(290);
      run_until_quiet();

      // Extreme positive setting, sender idle most of the time.
      send_idle_pct = 69;
      write_lens(64'hFFFF_FFFF, 64'hFFFF_FFFF, '1, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      add_random_points(290);
      run_until_quiet();

      // Extreme negative coefficients, zero focal lengths, receiver stalling.
      send_idle_pct = 0;
      rsp_stall_pct = 69;
      write_lens(64'h0, 64'h0, 64'h0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, 32'h8000_0000);
      add_random_points(290);
      run_until_quiet();

      // Raw random registers with both sides idling.
      send_idle_pct = 34;
      rsp_stall_pct = 34;
      write_lens({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                 $urandom, $urandom, $urandom, $urandom, $urandom);
      add_random_points(290);
      run_until_quiet();

      // Pressure: the sender keeps offering while the receiver holds off.
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      write_random_lens();
      add_random_points(290);
      pressure_phase = 1'b1;
      run_until_quiet();

      // Plausible lens, mixed idling.
      send_idle_pct = 34;
      rsp_stall_pct = 34;
      write_random_lens();
      add_random_points(300);
      run_until_quiet();

      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
